>>> rtl/core/sctd_pkg.sv
// Package for the sector cache tag directory.
// Holds command and status codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package sctd_pkg;

  // Input command codes.
  localparam logic [2:0] CMD_LOOKUP    = 3'd0;
  localparam logic [2:0] CMD_FILL_DONE = 3'd1;
  localparam logic [2:0] CMD_MARK      = 3'd2;
  localparam logic [2:0] CMD_FLUSH     = 3'd3;
  localparam logic [2:0] CMD_WB_DONE   = 3'd4;

  // Result status codes.
  localparam logic [3:0] STAT_HIT         = 4'd0;
  localparam logic [3:0] STAT_MISS        = 4'd1;
  localparam logic [3:0] STAT_FILL_OK     = 4'd2;
  localparam logic [3:0] STAT_FILL_FAIL   = 4'd3;
  localparam logic [3:0] STAT_MARKED      = 4'd4;
  localparam logic [3:0] STAT_MARK_IGNORE = 4'd5;
  localparam logic [3:0] STAT_WB_REQ      = 4'd6;
  localparam logic [3:0] STAT_FLUSH_EMPTY = 4'd7;
  localparam logic [3:0] STAT_CLEARED     = 4'd8;
  localparam logic [3:0] STAT_WB_FAIL     = 4'd9;

  // Most write-back requests one flush reports.
  localparam int FLUSH_MAX = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // Register the incoming item and its tag matches.
    logic exec;        // Carry out the registered command.
    logic flush_step;  // Examine the slot at the flush pointer.
  } sctd_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // The output register can take a result this cycle.
    logic walk_needed;  // The registered command is a flush with dirty slots.
    logic walk_done;    // The flush step emits its final request this cycle.
  } sctd_stat_t;

endpackage

>>> rtl/core/sctd_ctrl.sv
// Controller state machine of the sector cache tag directory.
// Depends on sctd_pkg for the command and status structs.
`timescale 1ns / 1ps

module sctd_ctrl
  import sctd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  sctd_stat_t stat_i,
  output sctd_ctrl_t ctrl_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_q, state_d;

  // Only an idle controller takes an input transfer.
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.out_free) begin
          ctrl_o.exec = 1'b1;
          state_d     = stat_i.walk_needed ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        ctrl_o.flush_step = 1'b1;
        if (stat_i.walk_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/sctd_datapath.sv
// Datapath of the sector cache tag directory: tag, valid and dirty registers,
// parallel tag compare, flush walk and the output register. Depends on sctd_pkg.
`timescale 1ns / 1ps

module sctd_datapath
  import sctd_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sctd_ctrl_t  ctrl_i,
  output sctd_stat_t  stat_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] sector_address_i,
  input  logic [3:0]  slot_index_i,
  input  logic        transfer_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [3:0]  result_slot_o,
  output logic [31:0] result_address_o,
  output logic        last_o
);

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Directory state.
  logic [31:0]      tag_q [SLOTS];
  logic [SLOTS-1:0] valid_q, dirty_q;

  // Registered item and its tag matches.
  logic [2:0]       cmd_q;
  logic [31:0]      addr_q;
  logic [3:0]       slot_q;
  logic             ok_q;
  logic [SLOTS-1:0] match_q;

  // Flush walk.
  logic [SlotW-1:0] ptr_q, ptr_d;
  logic [3:0]       cnt_q, cnt_d;

  // Output register.
  logic        out_valid_q;
  logic [3:0]  status_q, status_d;
  logic [3:0]  rslot_q, rslot_d;
  logic [31:0] raddr_q, raddr_d;
  logic        last_q, last_d;
  logic        load_out;

  logic [SLOTS-1:0] vd;
  logic [SlotW-1:0] hit_idx, victim_idx, slot_idx;
  logic             any_hit, in_range, ptr_vd, more_after, last_cond, emit;

  assign vd       = valid_q & dirty_q;
  assign any_hit  = |match_q;
  assign in_range = (32'(slot_q) < 32'(SLOTS));
  assign slot_idx = SlotW'(slot_q);

  // Lowest matching slot and lowest invalid slot.
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = SlotW'(i);
      end
      if (!valid_q[i]) begin
        victim_idx = SlotW'(i);
      end
    end
  end

  // Whether a dirty slot lies beyond the flush pointer.
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (vd[i] && (SlotW'(i) > ptr_q)) begin
        more_after = 1'b1;
      end
    end
  end

  assign ptr_vd    = vd[ptr_q];
  assign last_cond = !more_after || (cnt_q == 4'(FLUSH_MAX - 1));
  assign emit      = ctrl_i.flush_step && ptr_vd && stat_o.out_free;

  assign stat_o.out_free    = !out_valid_q || !out_stall_i;
  assign stat_o.walk_needed = (cmd_q == CMD_FLUSH) && (|vd);
  assign stat_o.walk_done   = emit && last_cond;

  // Capture the item and compare its address against every slot.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= command_i;
      addr_q <= sector_address_i;
      slot_q <= slot_index_i;
      ok_q   <= transfer_ok_i;
      for (int i = 0; i < SLOTS; i++) begin
        match_q[i] <= valid_q[i] && (tag_q[i] == sector_address_i);
      end
    end
  end

  // Result of the registered command or of the flush step.
  always_comb begin
    load_out = 1'b0;
    status_d = STAT_HIT;
    rslot_d  = '0;
    raddr_d  = '0;
    last_d   = 1'b1;
    if (ctrl_i.exec) begin
      case (cmd_q)
        CMD_LOOKUP: begin
          load_out = 1'b1;
          status_d = any_hit ? STAT_HIT : STAT_MISS;
          rslot_d  = any_hit ? 4'(hit_idx) : 4'(victim_idx);
        end
        CMD_FILL_DONE: begin
          load_out = 1'b1;
          status_d = (ok_q && in_range) ? STAT_FILL_OK : STAT_FILL_FAIL;
          rslot_d  = slot_q;
        end
        CMD_MARK: begin
          load_out = 1'b1;
          status_d = any_hit ? STAT_MARKED : STAT_MARK_IGNORE;
          rslot_d  = any_hit ? 4'(hit_idx) : 4'd0;
        end
        CMD_FLUSH: begin
          load_out = !(|vd);
          status_d = STAT_FLUSH_EMPTY;
        end
        CMD_WB_DONE: begin
          load_out = 1'b1;
          status_d = (ok_q && in_range) ? STAT_CLEARED : STAT_WB_FAIL;
          rslot_d  = slot_q;
        end
        default: begin
          load_out = 1'b0;
        end
      endcase
    end else if (emit) begin
      load_out = 1'b1;
      status_d = STAT_WB_REQ;
      rslot_d  = 4'(ptr_q);
      raddr_d  = tag_q[ptr_q];
      last_d   = last_cond;
    end
  end

  // Flush pointer and request count.
  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (ctrl_i.exec) begin
      ptr_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.flush_step && (!ptr_vd || stat_o.out_free)) begin
      ptr_d = ptr_q + SlotW'(1);
      if (emit) begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  // Valid and dirty updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      if (ctrl_i.exec) begin
        case (cmd_q)
          CMD_FILL_DONE: begin
            if (ok_q && in_range) begin
              valid_q[slot_idx] <= 1'b1;
              dirty_q[slot_idx] <= 1'b0;
            end
          end
          CMD_MARK: begin
            if (any_hit) begin
              dirty_q[hit_idx] <= 1'b1;
            end
          end
          CMD_WB_DONE: begin
            if (ok_q && in_range) begin
              dirty_q[slot_idx] <= 1'b0;
            end
          end
          default: begin
            dirty_q <= dirty_q;
          end
        endcase
      end
    end
  end

  // Tags are written by a successful fill only.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && (cmd_q == CMD_FILL_DONE) && ok_q && in_range) begin
      tag_q[slot_idx] <= addr_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= status_d;
      rslot_q  <= rslot_d;
      raddr_q  <= raddr_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign result_slot_o    = rslot_q;
  assign result_address_o = raddr_q;
  assign last_o           = last_q;

endmodule

>>> rtl/core/sector_cache_tag_directory.sv
// Sector cache tag directory: the tag, valid and dirty directory of a fully
// associative write-back sector cache with SLOTS slots (1 to 16).
//
// The input channel carries a command with a sector address, a slot index and
// a transfer status; the output channel carries status, slot, address and a
// last flag. Both channels use valid/stall; a transfer happens when valid is
// high and stall is low.
// One item is in work at a time. An item is taken in the idle state, its tag
// compare is registered, and the exec state then writes its result into the
// output register once that register is free. A flush then walks the slots
// one per cycle, waiting at a valid dirty slot while the output register is
// not free, emitting one write-back request per valid dirty slot (at most 16).
// A stalled receiver holds the output register; the controller then waits
// with its result and input stall stays high.
// Reset clears all valid and dirty bits and the controller; tags stay
// undefined until a fill writes them.
`timescale 1ns / 1ps

module sector_cache_tag_directory
  import sctd_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] sector_address_i,
  input  logic [3:0]  slot_index_i,
  input  logic        transfer_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [3:0]  result_slot_o,
  output logic [31:0] result_address_o,
  output logic        last_o
);

  sctd_ctrl_t ctrl;
  sctd_stat_t stat;

  // Controller.
  sctd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Datapath.
  sctd_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .command_i        (command_i),
    .sector_address_i (sector_address_i),
    .slot_index_i     (slot_index_i),
    .transfer_ok_i    (transfer_ok_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .result_slot_o    (result_slot_o),
    .result_address_o (result_address_o),
    .last_o           (last_o)
  );

  // An accepted item is worked on alone: no second capture right after.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.capture |=> (in_stall_o && !ctrl.capture))
    else $error("input taken while an item is in work");

  // Only write-back requests leave more results to follow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (status_o == STAT_WB_REQ))
    else $error("non-final result that is not a write-back request");

  // The flush walk ends only with an emitted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.walk_done |=> (out_valid_o && last_o && (status_o == STAT_WB_REQ)))
    else $error("flush finished without a final write-back request");

endmodule

>>> test/testbench.sv
// Self-checking testbench for sector_cache_tag_directory: a directed table,
// a full-directory sweep and random lookup/fill/mark/flush traffic.
// Depends on sctd_pkg and the sector_cache_tag_directory RTL.
`timescale 1ns / 1ps

module testbench
  import sctd_pkg::*;
();

  localparam int NUM_SLOTS = 16;
  localparam int POOL_SIZE = 24;
  localparam int RANDOM_ITEMS = 135;

  // Command codes that the block ignores.
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  slot;
    logic [31:0] address;
    logic        last;
  } dir_response_t;

  // One directed row; typed rows carry their single expected response.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] addr;
    logic [3:0]  slot;
    logic        ok;
    logic        typed;
    logic [3:0]  exp_status;
    logic [3:0]  exp_slot;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{CMD_LOOKUP,    32'h0000_0000, 4'd0,  1'b0, 1'b1, STAT_MISS,        4'd0},
    '{CMD_FLUSH,     32'h0000_0000, 4'd0,  1'b0, 1'b1, STAT_FLUSH_EMPTY, 4'd0},
    '{CMD_MARK,      32'h1234_5678, 4'd0,  1'b0, 1'b1, STAT_MARK_IGNORE, 4'd0},
    '{CMD_WB_DONE,   32'h0000_0000, 4'd15, 1'b1, 1'b1, STAT_CLEARED,     4'd15},
    '{CMD_FILL_DONE, 32'hFFFF_FFFF, 4'd0,  1'b1, 1'b1, STAT_FILL_OK,     4'd0},
    '{CMD_FILL_DONE, 32'h0000_0000, 4'd15, 1'b0, 1'b1, STAT_FILL_FAIL,   4'd15},
    '{CMD_FILL_DONE, 32'h0000_0000, 4'd15, 1'b1, 1'b1, STAT_FILL_OK,     4'd15},
    '{CMD_LOOKUP,    32'hFFFF_FFFF, 4'd0,  1'b0, 1'b1, STAT_HIT,         4'd0},
    '{CMD_LOOKUP,    32'h0000_0000, 4'd0,  1'b0, 1'b1, STAT_HIT,         4'd15},
    '{CMD_LOOKUP,    32'hA5A5_A5A5, 4'd10, 1'b1, 1'b0, 4'd0,             4'd0},
    '{CMD_FILL_DONE, 32'hFFFF_FFFF, 4'd3,  1'b1, 1'b1, STAT_FILL_OK,     4'd3},
    '{CMD_LOOKUP,    32'hFFFF_FFFF, 4'd0,  1'b0, 1'b1, STAT_HIT,         4'd0},
    '{CMD_MARK,      32'hFFFF_FFFF, 4'd0,  1'b0, 1'b1, STAT_MARKED,      4'd0},
    '{CMD_MARK,      32'h0000_0000, 4'd0,  1'b0, 1'b1, STAT_MARKED,      4'd15},
    '{CMD_SPARE_A,   32'h5A5A_5A5A, 4'd5,  1'b1, 1'b0, 4'd0,             4'd0},
    '{CMD_FLUSH,     32'h0000_0000, 4'd0,  1'b0, 1'b0, 4'd0,             4'd0},
    '{CMD_WB_DONE,   32'h0000_0000, 4'd0,  1'b0, 1'b1, STAT_WB_FAIL,     4'd0},
    '{CMD_WB_DONE,   32'h0000_0000, 4'd0,  1'b1, 1'b1, STAT_CLEARED,     4'd0},
    '{CMD_SPARE_B,   32'hFFFF_FFFF, 4'd15, 1'b0, 1'b0, 4'd0,             4'd0},
    '{CMD_FLUSH,     32'hFFFF_FFFF, 4'd15, 1'b1, 1'b0, 4'd0,             4'd0},
    '{CMD_SPARE_C,   32'h0000_0000, 4'd0,  1'b1, 1'b0, 4'd0,             4'd0},
    '{CMD_WB_DONE,   32'h0000_0000, 4'd15, 1'b1, 1'b1, STAT_CLEARED,     4'd15},
    '{CMD_FILL_DONE, 32'h8000_0001, 4'd15, 1'b1, 1'b0, 4'd0,             4'd0},
    '{CMD_LOOKUP,    32'h0000_0000, 4'd7,  1'b0, 1'b0, 4'd0,             4'd0},
    '{CMD_FLUSH,     32'h0000_0000, 4'd0,  1'b0, 1'b0, 4'd0,             4'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  command_i;
  logic [31:0] sector_address_i;
  logic [3:0]  slot_index_i;
  logic        transfer_ok_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  status_o;
  logic [3:0]  result_slot_o;
  logic [31:0] result_address_o;
  logic        last_o;

  // Shadow copy of the directory state.
  logic [31:0] tag_copy   [NUM_SLOTS];
  logic        valid_copy [NUM_SLOTS];
  logic        dirty_copy [NUM_SLOTS];

  dir_response_t step_responses [$];
  dir_response_t due_responses [$];
  logic [31:0]   addr_pool [POOL_SIZE];

  int  mismatch_count = 0;
  int  responses_checked = 0;
  int  items_sent = 0;
  int  longest_flush = 0;
  bit  calm_window = 1'b0;

  sector_cache_tag_directory #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .sector_address_i(sector_address_i),
    .slot_index_i    (slot_index_i),
    .transfer_ok_i   (transfer_ok_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .result_slot_o   (result_slot_o),
    .result_address_o(result_address_o),
    .last_o          (last_o)
  );

  // Free-running 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Lowest valid slot holding the address, or -1.
  function automatic int match_slot(input logic [31:0] addr);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (valid_copy[i] && tag_copy[i] == addr) return i;
    end
    return -1;
  endfunction

  // Slot chosen on a miss: the first invalid one, else slot 0.
  function automatic int victim_slot();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!valid_copy[i]) return i;
    end
    return 0;
  endfunction

  function automatic void add_response(input logic [3:0] status, input int slot,
                                       input logic [31:0] address, input logic last);
    step_responses.push_back(dir_response_t'{status, 4'(slot), address, last});
  endfunction

  // Apply one command to the shadow directory and list the responses it causes.
  task automatic directory_step(input logic [2:0] cmd, input logic [31:0] addr,
                                input logic [3:0] slot, input logic ok);
    int hit;
    int count;
    dir_response_t tail;
    step_responses.delete();
    case (cmd)
      CMD_LOOKUP: begin
        hit = match_slot(addr);
        if (hit >= 0) add_response(STAT_HIT, hit, 32'd0, 1'b1);
        else add_response(STAT_MISS, victim_slot(), 32'd0, 1'b1);
      end
      CMD_FILL_DONE: begin
        if (ok && int'(slot) < NUM_SLOTS) begin
          tag_copy[slot] = addr;
          valid_copy[slot] = 1'b1;
          dirty_copy[slot] = 1'b0;
          add_response(STAT_FILL_OK, slot, 32'd0, 1'b1);
        end else begin
          add_response(STAT_FILL_FAIL, slot, 32'd0, 1'b1);
        end
      end
      CMD_MARK: begin
        hit = match_slot(addr);
        if (hit >= 0) begin
          dirty_copy[hit] = 1'b1;
          add_response(STAT_MARKED, hit, 32'd0, 1'b1);
        end else begin
          add_response(STAT_MARK_IGNORE, 0, 32'd0, 1'b1);
        end
      end
      CMD_FLUSH: begin
        count = 0;
        for (int i = 0; i < NUM_SLOTS && count < FLUSH_MAX; i++) begin
          if (valid_copy[i] && dirty_copy[i]) begin
            add_response(STAT_WB_REQ, i, tag_copy[i], 1'b0);
            count++;
          end
        end
        if (count == 0) begin
          add_response(STAT_FLUSH_EMPTY, 0, 32'd0, 1'b1);
        end else begin
          tail = step_responses.pop_back();
          tail.last = 1'b1;
          step_responses.push_back(tail);
        end
        if (count > longest_flush) longest_flush = count;
      end
      CMD_WB_DONE: begin
        if (ok && int'(slot) < NUM_SLOTS) begin
          dirty_copy[slot] = 1'b0;
          add_response(STAT_CLEARED, slot, 32'd0, 1'b1);
        end else begin
          add_response(STAT_WB_FAIL, slot, 32'd0, 1'b1);
        end
      end
      default: begin
        // Spare commands are dropped without a response.
      end
    endcase
  endtask

  // Present one command, wait for its transfer and record what it must produce.
  task automatic push_item(input logic [2:0] cmd, input logic [31:0] addr,
                           input logic [3:0] slot, input logic ok,
                           input logic typed = 1'b0,
                           input logic [3:0] exp_status = 4'd0,
                           input logic [3:0] exp_slot = 4'd0);
    @(negedge clk_i);
    if (!calm_window && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    sector_address_i <= addr;
    slot_index_i     <= slot;
    transfer_ok_i    <= ok;
    do @(posedge clk_i); while (in_stall_o);
    directory_step(cmd, addr, slot, ok);
    if (typed) begin
      due_responses.push_back(dir_response_t'{exp_status, exp_slot, 32'd0, 1'b1});
    end else begin
      foreach (step_responses[i]) due_responses.push_back(step_responses[i]);
    end
    if (cmd <= CMD_WB_DONE) items_sent++;
  endtask

  // The receiver stalls at random outside the calm window.
  always @(negedge clk_i) begin
    out_stall_i <= !calm_window && ($urandom_range(0, 99) < 19);
  end

  // Compare each output transfer with the oldest outstanding response.
  always @(posedge clk_i) begin : check_responses
    dir_response_t got;
    dir_response_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, result_slot_o, result_address_o, last_o};
      if (due_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response status=%0d slot=%0d addr=%h last=%0d",
                                  got.status, got.slot, got.address, got.last));
      end else begin
        want = due_responses.pop_front();
        responses_checked++;
        if (got.status !== want.status || got.slot !== want.slot ||
            got.address !== want.address || got.last !== want.last) begin
          report_mismatch($sformatf(
            "got status=%0d slot=%0d addr=%h last=%0d, want %0d/%0d/%h/%0d",
            got.status, got.slot, got.address, got.last,
            want.status, want.slot, want.address, want.last));
        end
      end
    end
  end

  initial begin : stimulus
    int base;
    int pick;
    int waited;
    logic [31:0] addr;
    logic [3:0] dirty_slots [$];
    in_valid_i       = 1'b0;
    command_i        = CMD_LOOKUP;
    sector_address_i = 32'd0;
    slot_index_i     = 4'd0;
    transfer_ok_i    = 1'b0;
    out_stall_i      = 1'b0;
    rst_ni           = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tag_copy[i]   = 32'd0;
      valid_copy[i] = 1'b0;
      dirty_copy[i] = 1'b0;
    end
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: corners, every command and the special cases.
    foreach (DIRECTED_ROWS[i]) begin
      push_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].slot,
                DIRECTED_ROWS[i].ok, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].exp_status, DIRECTED_ROWS[i].exp_slot);
    end
    base = items_sent;

    // Fill every slot, miss on a full directory, dirty them all and flush all 16.
    for (int s = 0; s < NUM_SLOTS; s++) begin
      push_item(CMD_FILL_DONE, $urandom, 4'(s), 1'b1);
    end
    push_item(CMD_LOOKUP, $urandom, 4'($urandom), 1'($urandom));
    for (int s = 0; s < NUM_SLOTS; s++) begin
      push_item(CMD_MARK, tag_copy[s], 4'($urandom), 1'($urandom));
    end
    push_item(CMD_FLUSH, $urandom, 4'($urandom), 1'($urandom));
    for (int s = 0; s < NUM_SLOTS; s++) begin
      push_item(CMD_WB_DONE, $urandom, 4'(s), 1'($urandom_range(0, 3) != 0));
    end

    // Random traffic, mostly miss-then-fill and flush-then-clean sequences.
    while (items_sent < base + RANDOM_ITEMS) begin
      calm_window = (items_sent >= base + 60) && (items_sent < base + 110);
      pick = $urandom_range(0, 99);
      addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 40) begin
        push_item(CMD_LOOKUP, addr, 4'($urandom), 1'($urandom));
        if (match_slot(addr) < 0) begin
          push_item(CMD_FILL_DONE, addr, 4'(victim_slot()), 1'($urandom_range(0, 9) != 0));
          if ($urandom_range(0, 1) == 1) push_item(CMD_MARK, addr, 4'($urandom), 1'($urandom));
        end
      end else if (pick < 55) begin
        if ($urandom_range(0, 4) == 0) addr = $urandom;
        push_item(CMD_MARK, addr, 4'($urandom), 1'($urandom));
      end else if (pick < 68) begin
        dirty_slots.delete();
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (valid_copy[s] && dirty_copy[s]) dirty_slots.push_back(4'(s));
        end
        push_item(CMD_FLUSH, $urandom, 4'($urandom), 1'($urandom));
        foreach (dirty_slots[i]) begin
          if ($urandom_range(0, 3) != 0) begin
            push_item(CMD_WB_DONE, $urandom, dirty_slots[i], 1'($urandom_range(0, 7) != 0));
          end
        end
      end else if (pick < 80) begin
        if ($urandom_range(0, 2) == 0) addr = $urandom;
        push_item(CMD_FILL_DONE, addr, 4'($urandom), 1'($urandom_range(0, 3) != 0));
      end else if (pick < 90) begin
        push_item(CMD_WB_DONE, $urandom, 4'($urandom), 1'($urandom));
      end else begin
        push_item(3'($urandom), $urandom, 4'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 19) == 0) addr_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
    end
    calm_window = 1'b0;

    // Drain the outstanding responses, then allow a few more cycles.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (due_responses.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (due_responses.size() != 0) begin
      report_mismatch($sformatf("%0d responses never arrived", due_responses.size()));
    end

    $display("Sent %0d commands (%0d from the directed table), checked %0d responses.",
             items_sent, base, responses_checked);
    $display("Longest flush listed %0d write-back requests; %0d mismatches.",
             longest_flush, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin : watchdog
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
